@@ hw/rtl/rgb2hsv_pkg.sv @@
// ----------------------------------------------------------------------------
// rgb2hsv_pkg
// shared constants for the rgb to hsv converter: hue scale and sector codes
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

	localparam int HUE_W  = 15;
	localparam int HUE_CW = 16;
	localparam int HUE_QW = 12;

	localparam logic signed [HUE_CW-1:0] HUE_SIXTH = 16'sd3840;
	localparam logic signed [HUE_CW-1:0] HUE_FULL  = 16'sd23040;

	localparam int SECT_W = 2;
	typedef logic [SECT_W-1:0] sect_t;

	localparam sect_t SECT_RED   = 2'd0;
	localparam sect_t SECT_GREEN = 2'd1;
	localparam sect_t SECT_BLUE  = 2'd2;

endpackage

@@ hw/rtl/rgb_to_hsv_converter.sv @@
// pipeline: stage 1 and stage 2 registers, the two dividers, then the stage 4 register;
//   the two dividers, with at most one quotient bit per stage, set the depth
// throughput: one pixel per clock, busy is never raised
// the receiver cannot stall; each result shows for one cycle with done high
// reset: arst_n clears all valid bits, payload registers are not reset
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// pipelined rgb to hsv conversion with hue in 1/64 degree units
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [CHANNEL_BITS-1:0] red,
	input  logic [CHANNEL_BITS-1:0] green,
	input  logic [CHANNEL_BITS-1:0] blue,
	output logic                    done,
	output logic [14:0]             hue,
	output logic [CHANNEL_BITS-1:0] saturation,
	output logic [CHANNEL_BITS-1:0] brightness
);

	import rgb2hsv_pkg::*;

	localparam int W      = CHANNEL_BITS;
	localparam int LAT    = (W > HUE_QW) ? W : HUE_QW;
	localparam int HSIDEW = SECT_W + 2;

	// stage 1: max, min, sector, signed difference
	logic         req;
	logic [W-1:0] mx_c;
	logic [W-1:0] mn_c;
	sect_t        sect_c;
	logic [W-1:0] a_c;
	logic [W-1:0] b_c;

	logic         vld_s1;
	logic [W-1:0] mx_s1;
	logic [W-1:0] d_s1;
	logic [W-1:0] mag_s1;
	logic         neg_s1;
	sect_t        sect_s1;

	assign req  = start && !busy;
	assign busy = 1'b0;

	always_comb begin
		mx_c = red;
		if (green > mx_c) begin
			mx_c = green;
		end
		if (blue > mx_c) begin
			mx_c = blue;
		end
		mn_c = red;
		if (green < mn_c) begin
			mn_c = green;
		end
		if (blue < mn_c) begin
			mn_c = blue;
		end
		if (red >= green && red >= blue) begin
			sect_c = SECT_RED;
			a_c    = green;
			b_c    = blue;
		end else if (green >= blue) begin
			sect_c = SECT_GREEN;
			a_c    = blue;
			b_c    = red;
		end else begin
			sect_c = SECT_BLUE;
			a_c    = red;
			b_c    = green;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req;
		end
	end

	always_ff @(posedge clk) begin
		mx_s1   <= mx_c;
		d_s1    <= mx_c - mn_c;
		neg_s1  <= a_c < b_c;
		mag_s1  <= (a_c < b_c) ? (b_c - a_c) : (a_c - b_c);
		sect_s1 <= sect_c;
	end

	// stage 2: scale numerators by full scale and by one sixth of a turn
	logic                vld_s2;
	logic [2*W-1:0]      satnum_s2;
	logic [W+HUE_QW-1:0] huenum_s2;
	logic [W-1:0]        mx_s2;
	logic [W-1:0]        d_s2;
	logic                neg_s2;
	logic                zero_s2;
	sect_t               sect_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		satnum_s2 <= {d_s1, {W{1'b0}}} - {{W{1'b0}}, d_s1};
		huenum_s2 <= {mag_s1, 12'b0} - {4'b0, mag_s1, 8'b0};
		mx_s2     <= mx_s1;
		d_s2      <= d_s1;
		neg_s2    <= neg_s1;
		zero_s2   <= d_s1 == '0;
		sect_s2   <= sect_s1;
	end

	// stage 3: dividers
	logic              sat_vld;
	logic [W-1:0]      sat_quo;
	logic              sat_rnz;
	logic [W-1:0]      sat_mx;
	logic              hue_vld;
	logic [HUE_QW-1:0] hue_quo;
	logic              hue_rnz;
	logic [HSIDEW-1:0] hue_side;

	rgb2hsv_div #(
		.DW     (W),
		.QW     (W),
		.STAGES (LAT),
		.SW     (W)
	) u_sat_div (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_s2),
		.num    (satnum_s2),
		.den    (mx_s2),
		.side   (mx_s2),
		.q_vld  (sat_vld),
		.quo    (sat_quo),
		.rnz    (sat_rnz),
		.q_side (sat_mx)
	);

	rgb2hsv_div #(
		.DW     (W),
		.QW     (HUE_QW),
		.STAGES (LAT),
		.SW     (HSIDEW)
	) u_hue_div (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_s2),
		.num    (huenum_s2),
		.den    (d_s2),
		.side   ({sect_s2, neg_s2, zero_s2}),
		.q_vld  (hue_vld),
		.quo    (hue_quo),
		.rnz    (hue_rnz),
		.q_side (hue_side)
	);

	// stage 4: sector offset, floor correction, wrap
	sect_t                     d_sect;
	logic                      d_neg;
	logic                      d_zero;
	logic signed [HUE_CW-1:0]  base;
	logic signed [HUE_CW-1:0]  qs;
	logic signed [HUE_CW-1:0]  h_raw;
	logic signed [HUE_CW-1:0]  h_wrap;

	logic                      vld_s4;
	logic [HUE_W-1:0]          hue_s4;
	logic [W-1:0]              sat_s4;
	logic [W-1:0]              bright_s4;

	assign {d_sect, d_neg, d_zero} = hue_side;

	always_comb begin
		case (d_sect)
			SECT_RED:   base = '0;
			SECT_GREEN: base = HUE_SIXTH + HUE_SIXTH;
			SECT_BLUE:  base = (HUE_SIXTH + HUE_SIXTH) + (HUE_SIXTH + HUE_SIXTH);
			default:    base = '0;
		endcase
		qs = signed'({{(HUE_CW-HUE_QW){1'b0}}, hue_quo});
		if (d_neg) begin
			h_raw = base - qs - signed'({{(HUE_CW-1){1'b0}}, hue_rnz});
		end else begin
			h_raw = base + qs;
		end
		h_wrap = (h_raw < 0) ? (h_raw + HUE_FULL) : h_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= hue_vld;
		end
	end

	always_ff @(posedge clk) begin
		hue_s4    <= d_zero ? '0 : h_wrap[HUE_W-1:0];
		sat_s4    <= d_zero ? '0 : sat_quo;
		bright_s4 <= sat_mx;
	end

	assign done       = vld_s4;
	assign hue        = hue_s4;
	assign saturation = sat_s4;
	assign brightness = bright_s4;

	// checks
	a_no_busy : assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_div_align : assert property (@(posedge clk) disable iff (!arst_n)
		sat_vld == hue_vld)
		else $error("divider valids out of step");

	a_hue_range : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> hue < 15'd23040)
		else $error("hue out of range");

	a_black : assert property (@(posedge clk) disable iff (!arst_n)
		done && brightness == '0 |-> saturation == '0 && hue == '0)
		else $error("black pixel gives nonzero hue or saturation");

	a_rem_used : assert property (@(posedge clk) disable iff (!arst_n)
		sat_vld && sat_mx == '0 |=> !done || saturation == '0)
		else $error("saturation not cleared for black pixel");

	logic unused_rnz;
	assign unused_rnz = sat_rnz;

endmodule

@@ hw/rtl/rgb2hsv_div.sv @@
// ----------------------------------------------------------------------------
// rgb2hsv_div
// pipelined restoring divider, one quotient bit per stage for the first QW stages, with side data
// ----------------------------------------------------------------------------
module rgb2hsv_div #(
	parameter int DW     = 8,
	parameter int QW     = 12,
	parameter int STAGES = 12,
	parameter int SW     = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld,
	input  logic [DW+QW-1:0]   num,
	input  logic [DW-1:0]      den,
	input  logic [SW-1:0]      side,
	output logic               q_vld,
	output logic [QW-1:0]      quo,
	output logic               rnz,
	output logic [SW-1:0]      q_side
);

	logic          vld_s  [1:STAGES];
	logic [DW-1:0] rem_s  [1:STAGES];
	logic [QW-1:0] low_s  [1:STAGES];
	logic [QW-1:0] quo_s  [1:STAGES];
	logic [DW-1:0] den_s  [1:STAGES];
	logic [SW-1:0] side_s [1:STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic          vld_i;
		logic [DW-1:0] rem_i;
		logic [QW-1:0] low_i;
		logic [QW-1:0] quo_i;
		logic [DW-1:0] den_i;
		logic [SW-1:0] side_i;
		logic [DW-1:0] rem_n;
		logic [QW-1:0] low_n;
		logic [QW-1:0] quo_n;

		if (i == 0) begin : g_first
			assign vld_i  = vld;
			assign rem_i  = num[DW+QW-1:QW];
			assign low_i  = num[QW-1:0];
			assign quo_i  = '0;
			assign den_i  = den;
			assign side_i = side;
		end else begin : g_next
			assign vld_i  = vld_s[i];
			assign rem_i  = rem_s[i];
			assign low_i  = low_s[i];
			assign quo_i  = quo_s[i];
			assign den_i  = den_s[i];
			assign side_i = side_s[i];
		end

		if (i < QW) begin : g_div
			logic [DW:0]   trial;
			logic [DW-1:0] diff;
			logic          ge;

			always_comb begin
				trial = {rem_i, low_i[QW-1]};
				diff  = trial[DW-1:0] - den_i;
				ge    = trial >= {1'b0, den_i};
				rem_n = ge ? diff : trial[DW-1:0];
				low_n = {low_i[QW-2:0], 1'b0};
				quo_n = {quo_i[QW-2:0], ge};
			end
		end else begin : g_hold
			assign rem_n = rem_i;
			assign low_n = low_i;
			assign quo_n = quo_i;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1]  <= rem_n;
			low_s[i+1]  <= low_n;
			quo_s[i+1]  <= quo_n;
			den_s[i+1]  <= den_i;
			side_s[i+1] <= side_i;
		end
	end

	assign q_vld  = vld_s[STAGES];
	assign quo    = quo_s[STAGES];
	assign rnz    = rem_s[STAGES] != '0;
	assign q_side = side_s[STAGES];

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks rgb_to_hsv_converter pixel by pixel against an integer hsv predictor,
// with directed corner pixels first, then random pixels with random start gaps
// ----------------------------------------------------------------------------
module tb;
	import rgb2hsv_pkg::*;

	localparam int CH_BITS    = 8;
	localparam int CMAX       = (1 << CH_BITS) - 1;
	localparam int RAND_ITEMS = 700;
	localparam int BLOCK_LEN  = 50;
	localparam int IDLE_LIMIT = 1000;
	localparam int DRAIN_WAIT = 20;

	typedef struct packed {
		logic [HUE_W-1:0]   hue;
		logic [CH_BITS-1:0] sat;
		logic [CH_BITS-1:0] val;
	} hsv_t;

	localparam logic [23:0] EDGE_PIXELS [22] = '{
		24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00,
		24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h010000, 24'hFF0001,
		24'hFFFE00, 24'h00FF01, 24'h01FF00, 24'h0100FF, 24'h0001FF, 24'hFEFFFF,
		24'hFFFEFE, 24'h7F8080, 24'hFF7F00, 24'h80FF80
	};

	class hsv_scoreboard;
		hsv_t pending_hsv [$];
		int   errors;
		int   pixels_in;
		int   results_out;
		int   grey_hits;
		int   wrap_hits;
		int   sect_hits [3];

		function int sector_floor(int num, int den);
			int p;
			p = num * int'(HUE_SIXTH);
			if (p >= 0)
				return p / den;
			return -((-p + den - 1) / den);
		endfunction

		function hsv_t hsv_of(int r, int g, int b, output sect_t sect, output bit wrapped);
			hsv_t res;
			int   mx;
			int   mn;
			int   d;
			int   h;
			int   s;
			mx = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			mn = r;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			d = mx - mn;
			s = (mx != 0) ? d * CMAX / mx : 0;
			h = 0;
			wrapped = 1'b0;
			if (mx == r) sect = SECT_RED;
			else if (mx == g) sect = SECT_GREEN;
			else sect = SECT_BLUE;
			if (s != 0 && d > 0) begin
				case (sect)
					SECT_RED: h = sector_floor(g - b, d);
					SECT_GREEN: h = 2 * int'(HUE_SIXTH) + sector_floor(b - r, d);
					default: h = 4 * int'(HUE_SIXTH) + sector_floor(r - g, d);
				endcase
				if (h < 0) begin
					h += int'(HUE_FULL);
					wrapped = 1'b1;
				end
				if (h >= int'(HUE_FULL))
					h -= int'(HUE_FULL);
			end
			res.hue = h[HUE_W-1:0];
			res.sat = s[CH_BITS-1:0];
			res.val = mx[CH_BITS-1:0];
			return res;
		endfunction

		function void note_pixel(logic [CH_BITS-1:0] r, logic [CH_BITS-1:0] g,
				logic [CH_BITS-1:0] b);
			sect_t sect;
			bit    wrapped;
			hsv_t  exp_hsv;
			exp_hsv = hsv_of(int'(r), int'(g), int'(b), sect, wrapped);
			pending_hsv.push_back(exp_hsv);
			pixels_in++;
			if (exp_hsv.sat == 0)
				grey_hits++;
			else
				sect_hits[sect]++;
			if (wrapped)
				wrap_hits++;
		endfunction

		function void check_hsv(logic [HUE_W-1:0] h, logic [CH_BITS-1:0] s,
				logic [CH_BITS-1:0] v);
			hsv_t exp_hsv;
			results_out++;
			if (pending_hsv.size() == 0) begin
				$display("%0t: unexpected result hue %0d sat %0d val %0d", $time, h, s, v);
				errors++;
				return;
			end
			exp_hsv = pending_hsv.pop_front();
			if (h !== exp_hsv.hue) begin
				$display("%0t: hue mismatch, expected %0d, got %0d", $time, exp_hsv.hue, h);
				errors++;
			end
			if (s !== exp_hsv.sat) begin
				$display("%0t: saturation mismatch, expected %0d, got %0d", $time,
					exp_hsv.sat, s);
				errors++;
			end
			if (v !== exp_hsv.val) begin
				$display("%0t: brightness mismatch, expected %0d, got %0d", $time,
					exp_hsv.val, v);
				errors++;
			end
		endfunction

		function int pending();
			return pending_hsv.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [CH_BITS-1:0] red = '0;
	logic [CH_BITS-1:0] green = '0;
	logic [CH_BITS-1:0] blue = '0;
	logic               done;
	logic [HUE_W-1:0]   hue;
	logic [CH_BITS-1:0] saturation;
	logic [CH_BITS-1:0] brightness;

	hsv_scoreboard sb;
	int            idle_cycles = 0;

	rgb_to_hsv_converter #(
		.CHANNEL_BITS(CH_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.red(red),
		.green(green),
		.blue(blue),
		.done(done),
		.hue(hue),
		.saturation(saturation),
		.brightness(brightness)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_pixel(red, green, blue);
		if (arst_n && done)
			sb.check_hsv(hue, saturation, brightness);
	end

	always @(posedge clk) begin
		if ((arst_n && start && !busy) || (arst_n && done))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no request or result for %0d cycles", $time, IDLE_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_pixel(logic [CH_BITS-1:0] r, logic [CH_BITS-1:0] g,
			logic [CH_BITS-1:0] b);
		red   <= r;
		green <= g;
		blue  <= b;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic pixel_gap(bit burst);
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (burst || pick < 60)
			n = 0;
		else if (pick < 92)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(8, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic int clip_channel(int v);
		return (v > CMAX) ? CMAX : v;
	endfunction

	task automatic random_pixel(output logic [CH_BITS-1:0] r, output logic [CH_BITS-1:0] g,
			output logic [CH_BITS-1:0] b);
		int mode;
		int base;
		int hi;
		int lo;
		int k;
		mode = $urandom_range(0, 9);
		case (mode)
			5, 6: begin
				// near grey, small spread
				base = $urandom_range(0, CMAX);
				r = CH_BITS'(clip_channel(base + $urandom_range(0, 4)));
				g = CH_BITS'(clip_channel(base + $urandom_range(0, 4)));
				b = CH_BITS'(clip_channel(base + $urandom_range(0, 4)));
			end
			7: begin
				// two or three channels share the maximum
				hi = $urandom_range(1, CMAX);
				lo = $urandom_range(0, hi);
				k = $urandom_range(0, 3);
				r = CH_BITS'((k == 1) ? lo : hi);
				g = CH_BITS'((k == 2) ? lo : hi);
				b = CH_BITS'((k == 0) ? lo : hi);
			end
			8: begin
				r = CH_BITS'(($urandom_range(0, 2) == 0) ? $urandom_range(0, CMAX) :
					($urandom_range(0, 1) ? CMAX : 0));
				g = CH_BITS'(($urandom_range(0, 2) == 0) ? $urandom_range(0, CMAX) :
					($urandom_range(0, 1) ? CMAX : 0));
				b = CH_BITS'(($urandom_range(0, 2) == 0) ? $urandom_range(0, CMAX) :
					($urandom_range(0, 1) ? CMAX : 0));
			end
			9: begin
				r = CH_BITS'($urandom_range(0, 3));
				g = CH_BITS'($urandom_range(0, 3));
				b = CH_BITS'($urandom_range(0, 3));
			end
			default: begin
				r = CH_BITS'($urandom_range(0, CMAX));
				g = CH_BITS'($urandom_range(0, CMAX));
				b = CH_BITS'($urandom_range(0, CMAX));
			end
		endcase
	endtask

	initial begin
		logic [CH_BITS-1:0] r;
		logic [CH_BITS-1:0] g;
		logic [CH_BITS-1:0] b;
		bit                 burst;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (EDGE_PIXELS[i]) begin
			send_pixel(EDGE_PIXELS[i][23:16], EDGE_PIXELS[i][15:8], EDGE_PIXELS[i][7:0]);
			pixel_gap(1'b0);
		end

		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % BLOCK_LEN == 0)
				burst = ($urandom_range(0, 3) == 0);
			random_pixel(r, g, b);
			send_pixel(r, g, b);
			pixel_gap(burst);
		end
		start <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("pixels %0d, results %0d, grey or black %0d, negative hue wraps %0d",
			sb.pixels_in, sb.results_out, sb.grey_hits, sb.wrap_hits);
		$display("max channel red %0d, green %0d, blue %0d",
			sb.sect_hits[SECT_RED], sb.sect_hits[SECT_GREEN], sb.sect_hits[SECT_BLUE]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

@@ files.f @@
hw/rtl/rgb2hsv_pkg.sv
hw/rtl/rgb2hsv_div.sv
hw/rtl/rgb_to_hsv_converter.sv
dv/tb.sv
